/* hw/rtl/u128au_pkg.sv */
// Package for the 128-bit arithmetic unit: constants, codes and shared types.
`default_nettype none

package u128au_pkg;

  // Default working width and the fixed widths of the port fields
  localparam int unsigned WORD_BITS_DEF = 128;
  localparam int unsigned HALF_BITS     = 64;
  localparam int unsigned FULL_BITS     = 2 * HALF_BITS;
  localparam int unsigned FUNC_BITS     = 3;

  // Operation codes
  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_DIV = 3'd3,
    FUNC_SHL = 3'd4,
    FUNC_SHR = 3'd5
  } func_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_e;

  // Control for the shared adder/subtractor
  typedef struct packed {
    logic sub;   // x - y instead of x + y
    logic gate;  // force y to zero (multiplier bit clear)
  } addsub_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/u128au_if.sv */
// Handshake interfaces for the operand words and the result words.
`default_nettype none

interface u128au_in_if;
  logic                                valid;
  logic                                ready;
  logic [u128au_pkg::FUNC_BITS-1:0]    func;
  logic [u128au_pkg::HALF_BITS-1:0]    a_hi;
  logic [u128au_pkg::HALF_BITS-1:0]    a_lo;
  logic [u128au_pkg::HALF_BITS-1:0]    b_hi;
  logic [u128au_pkg::HALF_BITS-1:0]    b_lo;

  modport source (output valid, func, a_hi, a_lo, b_hi, b_lo, input ready);
  modport sink   (input valid, func, a_hi, a_lo, b_hi, b_lo, output ready);
endinterface

interface u128au_out_if;
  logic                                valid;
  logic                                ready;
  logic [u128au_pkg::HALF_BITS-1:0]    result_hi;
  logic [u128au_pkg::HALF_BITS-1:0]    result_lo;
  logic [u128au_pkg::HALF_BITS-1:0]    remainder_hi;
  logic [u128au_pkg::HALF_BITS-1:0]    remainder_lo;
  logic                                is_less;
  logic                                is_equal;
  logic                                is_greater;
  logic                                div_zero;

  modport source (output valid, result_hi, result_lo, remainder_hi, remainder_lo,
                  is_less, is_equal, is_greater, div_zero, input ready);
  modport sink   (input valid, result_hi, result_lo, remainder_hi, remainder_lo,
                  is_less, is_equal, is_greater, div_zero, output ready);
endinterface

`default_nettype wire

/* hw/rtl/uint128_arith_unit.sv */
// Top level of the unsigned 128-bit arithmetic unit (add, sub, mul, div, shifts).
//
//   channel   dir   words               handshake
//   in_i      in    func, a, b          valid/ready
//   out_o     out   result, remainder,  valid/ready
//                   compare flags, div_zero
//
// Multiply and divide step once per bit through the shared adder, staying in
// EXEC until the bit counter runs down to zero; add, subtract, shifts and
// divide by zero pass through EXEC once. Every operation then goes to DONE,
// writes the output register and returns to IDLE to take the next word.
// in_i.ready is high only in IDLE. A result that is not taken holds in the output
// register; the sequencer waits in DONE until it frees up. Async reset to IDLE.
`default_nettype none

module uint128_arith_unit #(
  parameter int unsigned WORD_BITS = u128au_pkg::WORD_BITS_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  u128au_in_if.sink    in_i,
  u128au_out_if.source out_o
);

  localparam int unsigned W     = WORD_BITS;
  localparam int unsigned AMT_W = $clog2(W);
  localparam int unsigned CNT_W = $clog2(W);
  localparam int unsigned FB    = u128au_pkg::FULL_BITS;
  localparam int unsigned HB    = u128au_pkg::HALF_BITS;

  // Sequencer and working registers
  u128au_pkg::state_e state_q, state_d;
  u128au_pkg::func_e  func_q, func_d;
  logic [W-1:0]       a_q, a_d;     // multiplicand / dividend then quotient
  logic [W-1:0]       b_q, b_d;     // multiplier / divisor / addend
  logic [W-1:0]       acc_q, acc_d; // product / partial remainder / result
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [AMT_W-1:0]   amt_q, amt_d;
  logic               big_q, big_d; // shift amount out of range
  logic               bz_q, bz_d;   // divisor is zero
  logic               lt_q, lt_d;
  logic               eq_q, eq_d;

  // Output register
  logic               ovalid_q, ovalid_d;
  logic [FB-1:0]      ores_q, ores_d;
  logic [FB-1:0]      orem_q, orem_d;
  logic               olt_q, olt_d;
  logic               oeq_q, oeq_d;
  logic               ogt_q, ogt_d;
  logic               odz_q, odz_d;

  // Operands cut to the working width
  logic [FB-1:0] a_full, b_full;
  logic [W-1:0]  a_cut, b_cut;
  assign a_full = {in_i.a_hi, in_i.a_lo};
  assign b_full = {in_i.b_hi, in_i.b_lo};
  assign a_cut  = a_full[W-1:0];
  assign b_cut  = b_full[W-1:0];

  // Shared adder hookup
  u128au_pkg::addsub_ctrl_t as_ctrl;
  logic [W:0]               as_x, as_y, as_sum;
  logic                     as_carry;

  u128au_addsub #(.WORD_BITS(WORD_BITS)) u_addsub (
    .ctrl_i  (as_ctrl),
    .x_i     (as_x),
    .y_i     (as_y),
    .sum_o   (as_sum),
    .carry_o (as_carry)
  );

  // Adder operand selection per operation
  always_comb begin
    as_ctrl = '0;
    as_x    = {1'b0, a_q};
    as_y    = {1'b0, b_q};
    unique case (func_q)
      u128au_pkg::FUNC_SUB: begin
        as_ctrl.sub = 1'b1;
      end
      u128au_pkg::FUNC_MUL: begin
        as_x         = {1'b0, acc_q};
        as_y         = {1'b0, a_q};
        as_ctrl.gate = ~b_q[0];
      end
      u128au_pkg::FUNC_DIV: begin
        // trial subtract of divisor from the shifted partial remainder
        as_x        = {acc_q, a_q[W-1]};
        as_ctrl.sub = 1'b1;
      end
      default: begin
        as_ctrl = '0;
      end
    endcase
  end

  logic out_take;
  assign out_take = ovalid_q & out_o.ready;

  // Next state and datapath
  always_comb begin
    state_d  = state_q;
    func_d   = func_q;
    a_d      = a_q;
    b_d      = b_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    amt_d    = amt_q;
    big_d    = big_q;
    bz_d     = bz_q;
    lt_d     = lt_q;
    eq_d     = eq_q;
    ovalid_d = ovalid_q & ~out_take;
    ores_d   = ores_q;
    orem_d   = orem_q;
    olt_d    = olt_q;
    oeq_d    = oeq_q;
    ogt_d    = ogt_q;
    odz_d    = odz_q;

    unique case (state_q)
      u128au_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          func_d  = u128au_pkg::func_e'(in_i.func);
          a_d     = a_cut;
          b_d     = b_cut;
          acc_d   = '0;
          cnt_d   = CNT_W'(W - 1);
          amt_d   = in_i.b_lo[AMT_W-1:0];
          big_d   = (in_i.b_lo >= HB'(W));
          bz_d    = (b_cut == '0);
          lt_d    = (a_cut < b_cut);
          eq_d    = (a_cut == b_cut);
          state_d = u128au_pkg::ST_EXEC;
        end
      end

      u128au_pkg::ST_EXEC: begin
        state_d = u128au_pkg::ST_DONE;
        unique case (func_q)
          u128au_pkg::FUNC_ADD,
          u128au_pkg::FUNC_SUB: begin
            acc_d = as_sum[W-1:0];
          end
          u128au_pkg::FUNC_MUL: begin
            acc_d = as_sum[W-1:0];
            a_d   = a_q << 1;
            b_d   = b_q >> 1;
            cnt_d = cnt_q - CNT_W'(1);
            if (cnt_q != '0) begin
              state_d = u128au_pkg::ST_EXEC;
            end
          end
          u128au_pkg::FUNC_DIV: begin
            if (bz_q) begin
              acc_d = '0;
              a_d   = '0;
            end else begin
              // restore when the trial subtract borrows
              acc_d = as_carry ? as_sum[W-1:0] : {acc_q[W-2:0], a_q[W-1]};
              a_d   = {a_q[W-2:0], as_carry};
              cnt_d = cnt_q - CNT_W'(1);
              if (cnt_q != '0) begin
                state_d = u128au_pkg::ST_EXEC;
              end
            end
          end
          u128au_pkg::FUNC_SHL: begin
            acc_d = big_q ? '0 : (a_q << amt_q);
          end
          u128au_pkg::FUNC_SHR: begin
            acc_d = big_q ? '0 : (a_q >> amt_q);
          end
          default: begin
            acc_d = '0;
          end
        endcase
      end

      u128au_pkg::ST_DONE: begin
        if (!ovalid_q || out_o.ready) begin
          ores_d = '0;
          orem_d = '0;
          if (func_q == u128au_pkg::FUNC_DIV) begin
            ores_d[W-1:0] = a_q;
            orem_d[W-1:0] = acc_q;
          end else begin
            ores_d[W-1:0] = acc_q;
          end
          olt_d    = lt_q;
          oeq_d    = eq_q;
          ogt_d    = ~lt_q & ~eq_q;
          odz_d    = (func_q == u128au_pkg::FUNC_DIV) & bz_q;
          ovalid_d = 1'b1;
          state_d  = u128au_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = u128au_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= u128au_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    cnt_q  <= cnt_d;
    amt_q  <= amt_d;
    big_q  <= big_d;
    bz_q   <= bz_d;
    lt_q   <= lt_d;
    eq_q   <= eq_d;
    ores_q <= ores_d;
    orem_q <= orem_d;
    olt_q  <= olt_d;
    oeq_q  <= oeq_d;
    ogt_q  <= ogt_d;
    odz_q  <= odz_d;
  end

  // Ports
  assign in_i.ready         = (state_q == u128au_pkg::ST_IDLE);
  assign out_o.valid        = ovalid_q;
  assign out_o.result_hi    = ores_q[FB-1:HB];
  assign out_o.result_lo    = ores_q[HB-1:0];
  assign out_o.remainder_hi = orem_q[FB-1:HB];
  assign out_o.remainder_lo = orem_q[HB-1:0];
  assign out_o.is_less      = olt_q;
  assign out_o.is_equal     = oeq_q;
  assign out_o.is_greater   = ogt_q;
  assign out_o.div_zero     = odz_q;

endmodule

`default_nettype wire

/* hw/rtl/u128au_addsub.sv */
// Shared (WORD_BITS+1)-bit adder/subtractor used by add, subtract, multiply and divide.
`default_nettype none

module u128au_addsub #(
  parameter int unsigned WORD_BITS = u128au_pkg::WORD_BITS_DEF
) (
  input  u128au_pkg::addsub_ctrl_t ctrl_i,
  input  logic [WORD_BITS:0]       x_i,
  input  logic [WORD_BITS:0]       y_i,
  output logic [WORD_BITS:0]       sum_o,
  output logic                     carry_o  // for subtract: 1 when x >= y
);

  logic [WORD_BITS:0]   y_gated;
  logic [WORD_BITS:0]   y_eff;
  logic [WORD_BITS+1:0] total;

  // Gate, invert for subtract, then one carry-chain add
  always_comb begin
    y_gated = ctrl_i.gate ? '0 : y_i;
    y_eff   = ctrl_i.sub ? ~y_gated : y_gated;
    total   = {1'b0, x_i} + {1'b0, y_eff} + (WORD_BITS+2)'(ctrl_i.sub);
  end

  assign sum_o   = total[WORD_BITS:0];
  assign carry_o = total[WORD_BITS+1];

endmodule

`default_nettype wire

/* hw/rtl/u128au_checker.sv */
// Port-level checker for the arithmetic unit, bound to the top level.
`default_nettype none

module u128au_checker (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               in_valid,
  input wire                               in_ready,
  input wire                               out_valid,
  input wire                               out_ready,
  input wire [u128au_pkg::HALF_BITS-1:0]   result_hi,
  input wire [u128au_pkg::HALF_BITS-1:0]   result_lo,
  input wire [u128au_pkg::HALF_BITS-1:0]   remainder_hi,
  input wire [u128au_pkg::HALF_BITS-1:0]   remainder_lo,
  input wire                               is_less,
  input wire                               is_equal,
  input wire                               is_greater,
  input wire                               div_zero
);

  // A stalled result word holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable({result_hi, result_lo, remainder_hi, remainder_lo}))
    else $error("result word changed while stalled");

  // Exactly one compare flag per result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> $onehot({is_less, is_equal, is_greater}))
    else $error("compare flags not one-hot");

  // Divide by zero returns zero quotient and remainder
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && div_zero |->
      result_hi == '0 && result_lo == '0 && remainder_hi == '0 && remainder_lo == '0)
    else $error("divide by zero result not zero");

  // One word at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

endmodule

bind uint128_arith_unit u128au_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .result_hi    (out_o.result_hi),
  .result_lo    (out_o.result_lo),
  .remainder_hi (out_o.remainder_hi),
  .remainder_lo (out_o.remainder_lo),
  .is_less      (out_o.is_less),
  .is_equal     (out_o.is_equal),
  .is_greater   (out_o.is_greater),
  .div_zero     (out_o.div_zero)
);

`default_nettype wire
